// ===== rtl/core/pseudo_color_map_generator_macros.svh =====
// Assertion macros used by the pseudo color map generator top level.
// Each macro clocks on clk_i and is disabled while rst_ni is low.
`ifndef PSEUDO_COLOR_MAP_GENERATOR_MACROS_SVH
`define PSEUDO_COLOR_MAP_GENERATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PCMG_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PCMG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/pcmg_pkg.sv =====
// Package for the pseudo color map generator: widths, map and segment codes,
// the per-segment coefficient table and the constant-divider reciprocals.
// No dependencies.
package pcmg_pkg;

  localparam int LEVEL_BITS = 10;
  localparam int LEVEL_MAX  = (1 << LEVEL_BITS) - 1;

  // Signed coefficient width and signed numerator width.
  localparam int COEF_W = 22;
  localparam int Y_W    = COEF_W + LEVEL_BITS + 1;
  // Numerators below the clamp limit fit in DIV_W unsigned bits.
  localparam int DIV_W  = LEVEL_BITS + 19;

  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;

  typedef enum logic [3:0] {
    MAP_JET, MAP_TURBO, MAP_HOT, MAP_COOL, MAP_BROWN_YELLOW,
    MAP_BLUE_RED, MAP_GREEN_RED, MAP_GREY, MAP_BWR, MAP_RDYLGN
  } map_e;

  typedef enum logic [1:0] {SEG_A, SEG_B, SEG_C, SEG_D} seg_e;

  // Denominator of a channel: one, three or one thousand times the full scale.
  typedef enum logic [1:0] {DEN_ONE, DEN_THREE, DEN_K} den_e;

  // Channel numerator 2N + M written as a * LEVEL_MAX + b * level.
  typedef struct packed {
    logic signed [COEF_W-1:0] a;
    logic signed [COEF_W-1:0] b;
    den_e                     den;
  } coef_t;

  typedef coef_t [2:0] pix_coef_t;

  typedef struct packed {
    logic signed [Y_W-1:0] y;
    den_e                  den;
  } chan_num_t;

  typedef chan_num_t [2:0] pix_num_t;

  // Full divisors 2 * M, shifts and rounded-up reciprocals.
  localparam longint unsigned DIV_C_ONE   = 64'(LEVEL_MAX) * 2;
  localparam longint unsigned DIV_C_THREE = 64'(LEVEL_MAX) * 6;
  localparam longint unsigned DIV_C_K     = 64'(LEVEL_MAX) * 2000;

  localparam int DIV_S_ONE   = DIV_W + $clog2(DIV_C_ONE);
  localparam int DIV_S_THREE = DIV_W + $clog2(DIV_C_THREE);
  localparam int DIV_S_K     = DIV_W + $clog2(DIV_C_K);

  localparam longint unsigned DIV_R_ONE =
    ((64'd1 << DIV_S_ONE) + DIV_C_ONE - 1) / DIV_C_ONE;
  localparam longint unsigned DIV_R_THREE =
    ((64'd1 << DIV_S_THREE) + DIV_C_THREE - 1) / DIV_C_THREE;
  localparam longint unsigned DIV_R_K =
    ((64'd1 << DIV_S_K) + DIV_C_K - 1) / DIV_C_K;

  // Quotients at or above 256 clamp to full scale.
  localparam longint unsigned DIV_LIM_ONE   = DIV_C_ONE * 256;
  localparam longint unsigned DIV_LIM_THREE = DIV_C_THREE * 256;
  localparam longint unsigned DIV_LIM_K     = DIV_C_K * 256;

  // Builds a channel from N = p * LEVEL_MAX + q * level over M = m * LEVEL_MAX.
  function automatic coef_t mk_coef(int p, int q, den_e den);
    coef_t res;
    int    m;
    unique case (den)
      DEN_THREE: m = 3;
      DEN_K:     m = 1000;
      default:   m = 1;
    endcase
    res.a   = COEF_W'(2 * p + m);
    res.b   = COEF_W'(2 * q);
    res.den = den;
    return res;
  endfunction

  function automatic coef_t full_coef();
    return mk_coef(255, 0, DEN_ONE);
  endfunction

  function automatic coef_t zero_coef();
    return mk_coef(0, 0, DEN_ONE);
  endfunction

  // Coefficients of the three channels for a map, quarter and hot-map segment.
  function automatic pix_coef_t map_coef(logic [3:0] map, seg_e quarter, seg_e hot_seg);
    pix_coef_t c;
    c[CH_RED]   = zero_coef();
    c[CH_GREEN] = zero_coef();
    c[CH_BLUE]  = zero_coef();
    unique case (map)
      MAP_JET: begin
        unique case (quarter)
          SEG_A: begin
            c[CH_GREEN] = mk_coef(0, 1020, DEN_ONE);
            c[CH_BLUE]  = full_coef();
          end
          SEG_B: begin
            c[CH_GREEN] = full_coef();
            c[CH_BLUE]  = mk_coef(510, -1020, DEN_ONE);
          end
          SEG_C: begin
            c[CH_RED]   = mk_coef(-510, 1020, DEN_ONE);
            c[CH_GREEN] = full_coef();
          end
          default: begin
            c[CH_RED]   = full_coef();
            c[CH_GREEN] = mk_coef(1020, -1020, DEN_ONE);
          end
        endcase
      end
      MAP_TURBO: begin
        unique case (quarter)
          SEG_A: begin
            c[CH_RED]   = mk_coef(33915, 272340, DEN_K);
            c[CH_GREEN] = mk_coef(0, 102000, DEN_K);
            c[CH_BLUE]  = mk_coef(135915, -170085, DEN_K);
          end
          SEG_B: begin
            c[CH_RED]   = mk_coef(-51000, 612000, DEN_K);
            c[CH_GREEN] = mk_coef(-204000, 918000, DEN_K);
            c[CH_BLUE]  = mk_coef(187170, -374340, DEN_K);
          end
          SEG_C: begin
            c[CH_RED]   = full_coef();
            c[CH_GREEN] = mk_coef(357000, -204000, DEN_K);
            c[CH_BLUE]  = mk_coef(-51000, 102000, DEN_K);
          end
          default: begin
            c[CH_RED]   = mk_coef(561000, -408000, DEN_K);
            c[CH_GREEN] = mk_coef(663000, -612000, DEN_K);
            c[CH_BLUE]  = mk_coef(-280500, 408000, DEN_K);
          end
        endcase
      end
      MAP_HOT: begin
        unique case (hot_seg)
          SEG_A: begin
            c[CH_RED]   = mk_coef(0, 2040, DEN_THREE);
          end
          SEG_B: begin
            c[CH_RED]   = full_coef();
            c[CH_GREEN] = mk_coef(-765, 2040, DEN_THREE);
          end
          default: begin
            c[CH_RED]   = full_coef();
            c[CH_GREEN] = full_coef();
            c[CH_BLUE]  = mk_coef(-765, 1020, DEN_ONE);
          end
        endcase
      end
      MAP_COOL: begin
        c[CH_RED]   = mk_coef(0, 255, DEN_ONE);
        c[CH_GREEN] = mk_coef(255, -255, DEN_ONE);
        c[CH_BLUE]  = full_coef();
      end
      MAP_BROWN_YELLOW: begin
        c[CH_RED]   = mk_coef(101, 154, DEN_ONE);
        c[CH_GREEN] = mk_coef(67, 188, DEN_ONE);
        c[CH_BLUE]  = mk_coef(33, -33, DEN_ONE);
      end
      MAP_BLUE_RED, MAP_BWR: begin
        if (quarter == SEG_A || quarter == SEG_B) begin
          c[CH_RED]   = mk_coef(0, 510, DEN_ONE);
          c[CH_GREEN] = mk_coef(0, 510, DEN_ONE);
          c[CH_BLUE]  = full_coef();
        end else begin
          c[CH_RED]   = full_coef();
          c[CH_GREEN] = mk_coef(510, -510, DEN_ONE);
          c[CH_BLUE]  = mk_coef(510, -510, DEN_ONE);
        end
      end
      MAP_GREEN_RED: begin
        if (quarter == SEG_A || quarter == SEG_B) begin
          c[CH_RED]   = mk_coef(0, 510, DEN_ONE);
          c[CH_GREEN] = full_coef();
        end else begin
          c[CH_RED]   = full_coef();
          c[CH_GREEN] = mk_coef(510, -510, DEN_ONE);
        end
      end
      MAP_GREY: begin
        c[CH_RED]   = mk_coef(0, 255, DEN_ONE);
        c[CH_GREEN] = mk_coef(0, 255, DEN_ONE);
        c[CH_BLUE]  = mk_coef(0, 255, DEN_ONE);
      end
      MAP_RDYLGN: begin
        if (quarter == SEG_A || quarter == SEG_B) begin
          c[CH_RED]   = full_coef();
          c[CH_GREEN] = mk_coef(0, 510, DEN_ONE);
        end else begin
          c[CH_RED]   = mk_coef(510, -510, DEN_ONE);
          c[CH_GREEN] = full_coef();
        end
      end
      default: begin
      end
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/core/pcmg_numer.sv =====
// Segment decode and numerator datapath of the pseudo color map generator.
// Depends on pcmg_pkg for the coefficient table and numerator types.
module pcmg_numer
  import pcmg_pkg::*;
(
  input  logic [LEVEL_BITS-1:0] level_i,
  input  logic [3:0]            map_select_i,
  output pix_num_t              num_o
);

  localparam int CMP_W = LEVEL_BITS + 3;
  localparam logic [CMP_W-1:0] FULL1 = CMP_W'(LEVEL_MAX);
  localparam logic [CMP_W-1:0] FULL3 = CMP_W'(3 * LEVEL_MAX);

  logic [CMP_W-1:0]      lvl_x2;
  logic [CMP_W-1:0]      lvl_x4;
  logic [CMP_W-1:0]      lvl_x8;
  seg_e                  quarter;
  seg_e                  hot_seg;
  pix_coef_t             coef;
  logic signed [Y_W-1:0] lvl_ext;

  assign lvl_x2  = {2'b00, level_i, 1'b0};
  assign lvl_x4  = {1'b0, level_i, 2'b00};
  assign lvl_x8  = {level_i, 3'b000};
  assign lvl_ext = $signed({{(Y_W - LEVEL_BITS){1'b0}}, level_i});

  always_comb begin
    priority if (lvl_x4 < FULL1) begin
      quarter = SEG_A;
    end else if (lvl_x2 < FULL1) begin
      quarter = SEG_B;
    end else if (lvl_x4 < FULL3) begin
      quarter = SEG_C;
    end else begin
      quarter = SEG_D;
    end
  end

  always_comb begin
    priority if (lvl_x8 < FULL3) begin
      hot_seg = SEG_A;
    end else if (lvl_x4 < FULL3) begin
      hot_seg = SEG_B;
    end else begin
      hot_seg = SEG_C;
    end
  end

  assign coef = map_coef(map_select_i, quarter, hot_seg);

  always_comb begin
    logic signed [Y_W-1:0] a_ext;
    logic signed [Y_W-1:0] b_ext;
    for (int ch = 0; ch < 3; ch++) begin
      a_ext = {{(Y_W - COEF_W){coef[ch].a[COEF_W-1]}}, coef[ch].a};
      b_ext = {{(Y_W - COEF_W){coef[ch].b[COEF_W-1]}}, coef[ch].b};
      num_o[ch].y   = (a_ext <<< LEVEL_BITS) - a_ext + b_ext * lvl_ext;
      num_o[ch].den = coef[ch].den;
    end
  end

endmodule

// ===== rtl/core/pcmg_div8.sv =====
// Rounding divider of one color channel: divides the numerator by a constant
// through a reciprocal multiply and clamps to 0..255. Depends on pcmg_pkg.
module pcmg_div8
  import pcmg_pkg::*;
(
  input  chan_num_t  num_i,
  output logic [7:0] chan_o
);

  localparam int PROD_W = 2 * DIV_W + 1;

  logic [Y_W-2:0]    y_mag;
  logic [DIV_W-1:0]  y_low;
  logic [DIV_W:0]    recip;
  logic [Y_W-2:0]    lim;
  logic [PROD_W-1:0] prod;
  logic [7:0]        quot;

  assign y_mag = num_i.y[Y_W-2:0];
  assign y_low = num_i.y[DIV_W-1:0];

  always_comb begin
    unique case (num_i.den)
      DEN_THREE: begin
        recip = (DIV_W + 1)'(DIV_R_THREE);
        lim   = (Y_W - 1)'(DIV_LIM_THREE);
      end
      DEN_K: begin
        recip = (DIV_W + 1)'(DIV_R_K);
        lim   = (Y_W - 1)'(DIV_LIM_K);
      end
      default: begin
        recip = (DIV_W + 1)'(DIV_R_ONE);
        lim   = (Y_W - 1)'(DIV_LIM_ONE);
      end
    endcase
  end

  assign prod = PROD_W'(y_low) * PROD_W'(recip);

  always_comb begin
    unique case (num_i.den)
      DEN_THREE: quot = prod[DIV_S_THREE +: 8];
      DEN_K:     quot = prod[DIV_S_K +: 8];
      default:   quot = prod[DIV_S_ONE +: 8];
    endcase
  end

  always_comb begin
    priority if (num_i.y[Y_W-1]) begin
      chan_o = 8'h00;
    end else if (y_mag >= lim) begin
      chan_o = 8'hFF;
    end else begin
      chan_o = quot;
    end
  end

endmodule

// ===== rtl/core/pseudo_color_map_generator.sv =====
// Top level of the pseudo color map generator: map register, numerator stage,
// result stage and handshake. Depends on pcmg_pkg, pcmg_numer, pcmg_div8.
//
//   Channel | Beat carries                 | Handshake
//   cfg     | map_select_i                 | cfg_valid_i / cfg_ready_o
//   in      | level_i                      | in_valid_i  / in_ready_o
//   out     | red_o, green_o, blue_o       | out_valid_o / out_ready_i
//
// One beat per clock in and out while the output is not stalled; a result is registered in both stages.
// The first stage holds the three channel numerators, the second the rounded
// colors after a reciprocal multiply per channel.
// Reset clears the stage valid flags and sets the map to jet.
// A stalled output holds its beat and the input keeps accepting until the
// numerator stage is also full.
`include "pseudo_color_map_generator_macros.svh"

module pseudo_color_map_generator
  import pcmg_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [3:0]            map_select_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [LEVEL_BITS-1:0] level_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            red_o,
  output logic [7:0]            green_o,
  output logic [7:0]            blue_o
);

  logic       [3:0] map_select_q;
  logic             s1_valid_q;
  pix_num_t         s1_num_q;
  pix_num_t         s1_num_d;
  logic       [3:0] s1_map_q;
  logic             out_valid_q;
  logic       [7:0] chan_d [3];
  logic       [7:0] red_q;
  logic       [7:0] green_q;
  logic       [7:0] blue_q;
  logic             out_load;
  logic             s1_load;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_select_q <= MAP_JET;
    end else if (cfg_valid_i) begin
      map_select_q <= map_select_i;
    end
  end

  assign out_load   = !out_valid_q || out_ready_i;
  assign s1_load    = !s1_valid_q || out_load;
  assign in_ready_o = s1_load;

  pcmg_numer u_numer (
    .level_i      (level_i),
    .map_select_i (map_select_q),
    .num_o        (s1_num_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_load) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_load) begin
      s1_num_q <= s1_num_d;
      s1_map_q <= map_select_q;
    end
  end

  for (genvar ch = 0; ch < 3; ch++) begin : g_chan
    pcmg_div8 u_div8 (
      .num_i  (s1_num_q[ch]),
      .chan_o (chan_d[ch])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && out_load) begin
      red_q   <= chan_d[CH_RED];
      green_q <= chan_d[CH_GREEN];
      blue_q  <= chan_d[CH_BLUE];
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;

  `PCMG_ASSERT_IMPL(a_ready_when_empty, !s1_valid_q, in_ready_o, "input blocked with empty stage")
  `PCMG_ASSERT_NEXT(a_stage_moves, s1_valid_q && out_load, out_valid_o, "beat lost between stages")
  `PCMG_ASSERT_NEXT(a_unused_map_black, s1_valid_q && out_load && (s1_map_q > MAP_RDYLGN), (red_o == 8'h00) && (green_o == 8'h00) && (blue_o == 8'h00), "unused map code not black")
  `PCMG_ASSERT_NEXT(a_cool_blue_full, s1_valid_q && out_load && (s1_map_q == MAP_COOL), blue_o == 8'hFF, "cool map blue not at full scale")

endmodule
